>>> sv/rectangle_char_rasterizer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle character rasterizer
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_CHAR_RASTERIZER_TOP_ASSERT_SVH
`define RECTANGLE_CHAR_RASTERIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RCR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RCR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RCR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RCR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants, codes and types of the rectangle character rasterizer.
// ----------------------------------------------------------------------------
package rcr_pkg;

   // frame store geometry
   localparam int MAX_DIM   = 256;
   localparam int DIM_BITS  = $clog2(MAX_DIM);
   localparam int ADDR_BITS = 2 * DIM_BITS;

   // field widths
   localparam int CFG_DIM_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;
   localparam int CHAR_W    = 7;
   localparam int KIND_W    = 2;
   localparam int POS_W     = 19;
   localparam int SPAN_W    = 18;
   localparam int BYTE_W    = 8;
   localparam int COORD_W   = 21;
   localparam int FRAC_BITS = 8;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // shape and character codes
   localparam logic [BYTE_W-1:0] SHAPE_FILLED  = 8'h52;
   localparam logic [BYTE_W-1:0] SHAPE_OUTLINE = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_MIN      = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_MAX      = 8'd126;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BG     = 2'd2;

   // register reset values
   localparam logic [CFG_DIM_W-1:0] DIM_RESET = 9'd1;
   localparam logic [CHAR_W-1:0]    BG_RESET  = 7'd32;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // classified command, front to back
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic                      bad;      // draw rejected
      logic                      filled;
      logic [CHAR_W-1:0]         edge_ch;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] left_p;   // left + 1.0
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] top_p;    // top + 1.0
      logic signed [COORD_W-1:0] bottom;
      logic [BYTE_W-1:0]         col;
      logic [BYTE_W-1:0]         row;
   } cmd_type;

   // back end status, seen by the top level
   typedef struct packed {
      logic pop;
      logic sweeping;
      logic mem_we;
   } back_stat_type;

endpackage

>>> sv/rectangle_char_rasterizer_top.sv
// ----------------------------------------------------------------------------
// rectangle_char_rasterizer_top
// Character frame store with clear, rectangle draw and single cell read.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per beat (valid/ready): kind 0 clears the area
//   in use to the background character, kind 1 draws a rectangle, kind 2
//   reads one cell. Every command gives exactly one rsp_* beat, in order:
//   rsp_cell_char is the read character (zero otherwise), rsp_status is set
//   when a draw is rejected.
//   csr_wen/csr_index/csr_wdata set width, height and background character;
//   write them only while no command is outstanding.
//   Clear and draw sweep the area in use one cell per cycle through the
//   single write port of the frame store. Commands run one at a time in the
//   back end; a two-entry queue in front takes up to two further commands
//   while a sweep is running.
//   Reset clears the queue and the sequencer; the frame store is not
//   cleared, so issue a clear before the first read.
//   When rsp_ready is held low the finished result waits in the response
//   register, the back end stops and the queue fills before req_ready drops.
// ----------------------------------------------------------------------------
`include "rectangle_char_rasterizer_top_assert.svh"

module rectangle_char_rasterizer_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rcr_pkg::KIND_W-1:0]    req_kind,
   input  logic [rcr_pkg::POS_W-1:0]     req_rect_left,
   input  logic [rcr_pkg::POS_W-1:0]     req_rect_top,
   input  logic [rcr_pkg::SPAN_W-1:0]    req_rect_span_x,
   input  logic [rcr_pkg::SPAN_W-1:0]    req_rect_span_y,
   input  logic [rcr_pkg::BYTE_W-1:0]    req_shape_code,
   input  logic [rcr_pkg::BYTE_W-1:0]    req_edge_char,
   input  logic [rcr_pkg::BYTE_W-1:0]    req_read_col,
   input  logic [rcr_pkg::BYTE_W-1:0]    req_read_row,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rcr_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic                          rsp_status,
   // register write port
   input  logic                          csr_wen,
   input  logic [rcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcr_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import rcr_pkg::*;

   logic [CFG_DIM_W-1:0] width_ff;
   logic [CFG_DIM_W-1:0] height_ff;
   logic [CHAR_W-1:0]    bg_ff;

   logic                 q_ready;
   logic                 q_push;
   cmd_type              push_cmd;
   logic                 q_valid;
   cmd_type              head_cmd;
   back_stat_type        back_stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         bg_ff     <= BG_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_BG:     bg_ff     <= csr_wdata[CHAR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rcr_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_span_x (req_rect_span_x),
      .req_rect_span_y (req_rect_span_y),
      .req_shape_code  (req_shape_code),
      .req_edge_char   (req_edge_char),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .q_ready         (q_ready),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   rcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop        (back_stat.pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   rcr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (head_cmd),
      .cfg_width     (width_ff),
      .cfg_height    (height_ff),
      .cfg_bg        (bg_ff),
      .stat          (back_stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_char (rsp_cell_char),
      .rsp_status    (rsp_status)
   );

   // checks
   `RCR_ASSERT_IMP(a_reject_no_char, clock, reset, rsp_valid && rsp_status, rsp_cell_char == '0, "rejected draw carries a character")
   `RCR_ASSERT_IMP(a_write_in_sweep, clock, reset, back_stat.mem_we, back_stat.sweeping, "frame store written outside a sweep")
   `RCR_ASSERT_IMP(a_pop_nonempty, clock, reset, back_stat.pop, q_valid, "pop from empty command queue")
   `RCR_ASSERT_NXT(a_single_pop, clock, reset, back_stat.pop, !back_stat.pop, "back end took two commands in a row")

endmodule

>>> sv/rcr_front.sv
// ----------------------------------------------------------------------------
// rcr_front
// Accepts request beats, checks draw commands and precomputes rectangle edges.
// ----------------------------------------------------------------------------
module rcr_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rcr_pkg::KIND_W-1:0] req_kind,
   input  logic [rcr_pkg::POS_W-1:0]  req_rect_left,
   input  logic [rcr_pkg::POS_W-1:0]  req_rect_top,
   input  logic [rcr_pkg::SPAN_W-1:0] req_rect_span_x,
   input  logic [rcr_pkg::SPAN_W-1:0] req_rect_span_y,
   input  logic [rcr_pkg::BYTE_W-1:0] req_shape_code,
   input  logic [rcr_pkg::BYTE_W-1:0] req_edge_char,
   input  logic [rcr_pkg::BYTE_W-1:0] req_read_col,
   input  logic [rcr_pkg::BYTE_W-1:0] req_read_row,
   input  logic                       q_ready,
   output logic                       q_push,
   output rcr_pkg::cmd_type           q_cmd
);
   import rcr_pkg::*;

   logic                      shape_ok;
   logic                      char_ok;
   logic                      span_ok;
   logic signed [COORD_W-1:0] left_ext;
   logic signed [COORD_W-1:0] top_ext;
   logic signed [COORD_W-1:0] sx_ext;
   logic signed [COORD_W-1:0] sy_ext;
   logic signed [COORD_W-1:0] one_fx;

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   // validity of a draw
   always_comb begin
      shape_ok = req_shape_code inside {SHAPE_FILLED, SHAPE_OUTLINE};
      char_ok  = req_edge_char inside {[CHAR_MIN:CHAR_MAX]};
      span_ok  = (req_rect_span_x != '0) && (req_rect_span_y != '0);
   end

   // widen coordinates, no wrap on the sums
   assign left_ext = {{(COORD_W-POS_W){req_rect_left[POS_W-1]}}, req_rect_left};
   assign top_ext  = {{(COORD_W-POS_W){req_rect_top[POS_W-1]}}, req_rect_top};
   assign sx_ext   = {{(COORD_W-SPAN_W){1'b0}}, req_rect_span_x};
   assign sy_ext   = {{(COORD_W-SPAN_W){1'b0}}, req_rect_span_y};
   assign one_fx   = COORD_W'(1 << FRAC_BITS);

   always_comb begin
      q_cmd         = '0;
      q_cmd.kind    = req_kind;
      q_cmd.bad     = (req_kind == KIND_DRAW) && !(shape_ok && char_ok && span_ok);
      q_cmd.filled  = (req_shape_code == SHAPE_FILLED);
      q_cmd.edge_ch = req_edge_char[CHAR_W-1:0];
      q_cmd.left    = left_ext;
      q_cmd.left_p  = left_ext + one_fx;
      q_cmd.right   = left_ext + sx_ext;
      q_cmd.top     = top_ext;
      q_cmd.top_p   = top_ext + one_fx;
      q_cmd.bottom  = top_ext + sy_ext;
      q_cmd.col     = req_read_col;
      q_cmd.row     = req_read_row;
   end

endmodule

>>> sv/rcr_queue.sv
// ----------------------------------------------------------------------------
// rcr_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rcr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rcr_pkg::cmd_type push_cmd,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output rcr_pkg::cmd_type head_cmd
);
   import rcr_pkg::*;

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/rcr_back.sv
// ----------------------------------------------------------------------------
// rcr_back
// Executes commands: clear and draw sweeps over the frame store, cell reads,
// and drives the response register.
// ----------------------------------------------------------------------------
module rcr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  rcr_pkg::cmd_type              q_cmd,
   input  logic [rcr_pkg::CFG_DIM_W-1:0] cfg_width,
   input  logic [rcr_pkg::CFG_DIM_W-1:0] cfg_height,
   input  logic [rcr_pkg::CHAR_W-1:0]    cfg_bg,
   output rcr_pkg::back_stat_type        stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rcr_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic                          rsp_status
);
   import rcr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   cmd_type               cmd_ff;
   cmd_type               cmd_in;
   logic [DIM_BITS-1:0]   col_ff;
   logic [DIM_BITS-1:0]   col_in;
   logic [DIM_BITS-1:0]   row_ff;
   logic [DIM_BITS-1:0]   row_in;
   logic [CHAR_W-1:0]     res_cell_ff;
   logic [CHAR_W-1:0]     res_cell_in;
   logic                  res_status_ff;
   logic                  res_status_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_cell_ff;
   logic [CHAR_W-1:0]     rsp_cell_in;
   logic                  rsp_status_ff;
   logic                  rsp_status_in;

   logic [CHAR_W-1:0]     mem [MAX_DIM * MAX_DIM];
   logic [CHAR_W-1:0]     rd_data_ff;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [CHAR_W-1:0]     wr_data;
   logic                  mem_we;

   logic [CFG_DIM_W-1:0]  w_use;
   logic [CFG_DIM_W-1:0]  h_use;
   logic [DIM_BITS-1:0]   last_col;
   logic [DIM_BITS-1:0]   last_row;
   logic                  area_empty;
   logic                  in_area;
   logic                  pop;

   logic signed [COORD_W-1:0] cx;
   logic signed [COORD_W-1:0] cx_p;
   logic signed [COORD_W-1:0] cy;
   logic signed [COORD_W-1:0] cy_p;
   logic                      inside_x;
   logic                      inside_y;
   logic                      border;
   logic [DIM_BITS:0]         col_nx;
   logic [DIM_BITS:0]         row_nx;

   // saturated area in use
   always_comb begin
      w_use      = (cfg_width  > CFG_DIM_W'(MAX_DIM)) ? CFG_DIM_W'(MAX_DIM) : cfg_width;
      h_use      = (cfg_height > CFG_DIM_W'(MAX_DIM)) ? CFG_DIM_W'(MAX_DIM) : cfg_height;
      last_col   = DIM_BITS'(w_use - 1'b1);
      last_row   = DIM_BITS'(h_use - 1'b1);
      area_empty = (w_use == '0) || (h_use == '0);
      in_area    = ({1'b0, cmd_ff.col} < w_use) && ({1'b0, cmd_ff.row} < h_use);
   end

   // cell position in fixed point, and the cell one step further
   always_comb begin
      col_nx   = {1'b0, col_ff} + 1'b1;
      row_nx   = {1'b0, row_ff} + 1'b1;
      cx       = {{(COORD_W-DIM_BITS-FRAC_BITS){1'b0}}, col_ff, {FRAC_BITS{1'b0}}};
      cy       = {{(COORD_W-DIM_BITS-FRAC_BITS){1'b0}}, row_ff, {FRAC_BITS{1'b0}}};
      cx_p     = {{(COORD_W-DIM_BITS-FRAC_BITS-1){1'b0}}, col_nx, {FRAC_BITS{1'b0}}};
      cy_p     = {{(COORD_W-DIM_BITS-FRAC_BITS-1){1'b0}}, row_nx, {FRAC_BITS{1'b0}}};
      inside_x = (cx >= cmd_ff.left) && (cx <= cmd_ff.right);
      inside_y = (cy >= cmd_ff.top) && (cy <= cmd_ff.bottom);
      // within 1.0 of an edge
      border   = (cx < cmd_ff.left_p) || (cx_p > cmd_ff.right) ||
                 (cy < cmd_ff.top_p) || (cy_p > cmd_ff.bottom);
   end

   // memory write during sweeps
   always_comb begin
      wr_addr = {row_ff, col_ff};
      rd_addr = {q_cmd.row[DIM_BITS-1:0], q_cmd.col[DIM_BITS-1:0]};
      if (cmd_ff.kind == KIND_CLEAR) begin
         wr_data = cfg_bg;
         mem_we  = (state_ff == ST_SWEEP);
      end else begin
         wr_data = cmd_ff.edge_ch;
         mem_we  = (state_ff == ST_SWEEP) && inside_x && inside_y &&
                   (border || cmd_ff.filled);
      end
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      res_cell_in   = res_cell_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop           = 1'b1;
               cmd_in        = q_cmd;
               col_in        = '0;
               row_in        = '0;
               res_cell_in   = '0;
               res_status_in = 1'b0;
               case (q_cmd.kind)
                  KIND_CLEAR: begin
                     state_in = area_empty ? ST_DONE : ST_SWEEP;
                  end
                  KIND_DRAW: begin
                     if (q_cmd.bad) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = area_empty ? ST_DONE : ST_SWEEP;
                     end
                  end
                  KIND_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (col_ff == last_col) begin
               col_in = '0;
               row_in = row_nx[DIM_BITS-1:0];
               if (row_ff == last_row) begin
                  state_in = ST_DONE;
               end
            end else begin
               col_in = col_nx[DIM_BITS-1:0];
            end
         end
         ST_READ: begin
            res_cell_in = in_area ? rd_data_ff : '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = res_cell_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      res_cell_ff   <= res_cell_in;
      res_status_ff <= res_status_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_status_ff <= rsp_status_in;
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.pop      = pop;
   assign stat.sweeping = (state_ff == ST_SWEEP);
   assign stat.mem_we   = mem_we;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_char = rsp_cell_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangle character rasterizer. A directed
// table covers reset defaults, invalid draws, outline and filled rectangles
// at the coordinate extremes and reads inside and outside the area. Random
// phases over several area sizes, from empty to oversized, follow. Every
// response beat is compared with a local model of the frame store, or with
// the answer typed into the directed table where there is one.
module tb;
   import rcr_pkg::*;

   localparam int          UNIT        = 1 << FRAC_BITS;    // 1.0 in fixed point
   localparam int          POS_MIN     = -(1 << (POS_W - 1));
   localparam int          POS_MAX     = (1 << (POS_W - 1)) - 1;
   localparam int          SPAN_MAX    = (1 << SPAN_W) - 1;
   localparam int          HOLD_CYCLES = 600;
   localparam int          TAIL_CYCLES = 50;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          RESET_ROWS  = 3;

   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam logic [CHAR_W-1:0]    BG_DIRECTED = 7'h23;    // '#'

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [POS_W-1:0]  left;
      logic signed [POS_W-1:0]  top;
      logic [SPAN_W-1:0]        span_x;
      logic [SPAN_W-1:0]        span_y;
      logic [BYTE_W-1:0]        shape;
      logic [BYTE_W-1:0]        edge_ch;
      logic [BYTE_W-1:0]        col;
      logic [BYTE_W-1:0]        row;
   } raster_cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_ch;
      logic              status;
   } cell_rsp_type;

   // answer typed into the directed table, if any
   typedef struct packed {
      logic         typed;
      cell_rsp_type rsp;
   } typed_rsp_type;

   typedef struct packed {
      raster_cmd_type cmd;
      typed_rsp_type  ans;
   } dir_row_type;

   localparam typed_rsp_type NO_ANSWER = '{typed: 1'b0, rsp: '{cell_ch: '0, status: 1'b0}};

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [POS_W-1:0]      req_rect_left = '0;
   logic [POS_W-1:0]      req_rect_top = '0;
   logic [SPAN_W-1:0]     req_rect_span_x = '0;
   logic [SPAN_W-1:0]     req_rect_span_y = '0;
   logic [BYTE_W-1:0]     req_shape_code = '0;
   logic [BYTE_W-1:0]     req_edge_char = '0;
   logic [BYTE_W-1:0]     req_read_col = '0;
   logic [BYTE_W-1:0]     req_read_row = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_W-1:0]     rsp_cell_char;
   logic                  rsp_status;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata = '0;

   // model state
   logic [CHAR_W-1:0]     frame_mirror [MAX_DIM*MAX_DIM];
   logic [CFG_DIM_W-1:0]  mirror_width  = DIM_RESET;
   logic [CFG_DIM_W-1:0]  mirror_height = DIM_RESET;
   logic [CHAR_W-1:0]     mirror_bg     = BG_RESET;

   // stimulus side: cells covered by a clear, so reads never hit unwritten cells
   bit                    cleared [MAX_DIM*MAX_DIM];

   cell_rsp_type          pending_cell_rsp [$];
   typed_rsp_type         typed_rsp_q [$];
   dir_row_type           dir_rows [$];

   int unsigned           fail_count = 0;
   int unsigned           cycle_count = 0;
   bit                    no_idle = 1'b0;
   bit                    sink_hold_req = 1'b0;

   rectangle_char_rasterizer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_span_x (req_rect_span_x),
      .req_rect_span_y (req_rect_span_y),
      .req_shape_code  (req_shape_code),
      .req_edge_char   (req_edge_char),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_char   (rsp_cell_char),
      .rsp_status      (rsp_status),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // columns or rows in use, oversized values saturate
   function automatic int unsigned dim_used(input logic [CFG_DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : d;
   endfunction

   // applies one command to the frame mirror and returns its response
   function automatic cell_rsp_type rasterize_cmd(input raster_cmd_type c);
      cell_rsp_type res;
      int unsigned  cols, rows;
      int           r, k;
      longint       left, top, right, bottom, px, py, sx, sy;
      bit           on_border;
      res  = '{cell_ch: '0, status: 1'b0};
      cols = dim_used(mirror_width);
      rows = dim_used(mirror_height);
      case (c.kind)
         KIND_CLEAR: begin
            for (r = 0; r < rows; r++)
               for (k = 0; k < cols; k++)
                  frame_mirror[r*MAX_DIM + k] = mirror_bg;
         end
         KIND_DRAW: begin
            if (!((c.shape == SHAPE_FILLED || c.shape == SHAPE_OUTLINE) &&
                  c.span_x != 0 && c.span_y != 0 &&
                  c.edge_ch >= CHAR_MIN && c.edge_ch <= CHAR_MAX)) begin
               res.status = 1'b1;
            end else begin
               left   = longint'(c.left);
               top    = longint'(c.top);
               sx     = longint'(c.span_x);
               sy     = longint'(c.span_y);
               right  = left + sx;
               bottom = top + sy;
               for (r = 0; r < rows; r++) begin
                  py = longint'(r) * UNIT;
                  if (py >= top && py <= bottom) begin
                     for (k = 0; k < cols; k++) begin
                        px = longint'(k) * UNIT;
                        if (px >= left && px <= right) begin
                           on_border = (px - left < UNIT) || (right - px < UNIT) ||
                                       (py - top < UNIT) || (bottom - py < UNIT);
                           if (on_border || c.shape == SHAPE_FILLED)
                              frame_mirror[r*MAX_DIM + k] = c.edge_ch[CHAR_W-1:0];
                        end
                     end
                  end
               end
            end
         end
         KIND_READ: begin
            if (c.col < cols && c.row < rows)
               res.cell_ch = frame_mirror[c.row*MAX_DIM + c.col];
         end
         default: ;
      endcase
      return res;
   endfunction

   // response check, then prediction for the request beat of this edge
   always @(posedge clock) begin : scoreboard
      raster_cmd_type c;
      cell_rsp_type   want;
      typed_rsp_type  ans;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_cell_rsp.size() == 0) begin
               $display("%0t: response beat with nothing pending, cell_char %0d status %0d",
                        $time, rsp_cell_char, rsp_status);
               fail_count++;
            end else begin
               want = pending_cell_rsp.pop_front();
               if (rsp_cell_char !== want.cell_ch) begin
                  $display("%0t: cell_char expected %0d, actual %0d",
                           $time, want.cell_ch, rsp_cell_char);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            c.kind    = req_kind;
            c.left    = req_rect_left;
            c.top     = req_rect_top;
            c.span_x  = req_rect_span_x;
            c.span_y  = req_rect_span_y;
            c.shape   = req_shape_code;
            c.edge_ch = req_edge_char;
            c.col     = req_read_col;
            c.row     = req_read_row;
            want      = rasterize_cmd(c);
            ans       = typed_rsp_q.pop_front();
            if (ans.typed)
               want = ans.rsp;
            pending_cell_rsp.push_back(want);
         end
      end
   end

   // idle length: mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 96)
         return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // response sink: random ready, with one long hold-off on request
   initial begin : rsp_sink
      int unsigned run_left;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            run_left = HOLD_CYCLES;
         end else if (run_left > 0) begin
            run_left--;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            run_left = $urandom_range(0, 8);
         end else begin
            rsp_ready <= 1'b0;
            run_left = pick_gap();
         end
      end
   end

   function automatic raster_cmd_type plain_cmd(input logic [KIND_W-1:0] kind);
      raster_cmd_type c;
      logic [127:0]   raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      c = raw[$bits(raster_cmd_type)-1:0];
      c.kind = kind;
      return c;
   endfunction

   function automatic raster_cmd_type read_cmd(input int col, input int row);
      raster_cmd_type c;
      c = plain_cmd(KIND_READ);
      c.col = BYTE_W'(col);
      c.row = BYTE_W'(row);
      return c;
   endfunction

   function automatic raster_cmd_type draw_cmd(input int left, input int top, input int sx,
                                               input int sy, input int shape, input int ch);
      raster_cmd_type c;
      c = plain_cmd(KIND_DRAW);
      c.left    = POS_W'(left);
      c.top     = POS_W'(top);
      c.span_x  = SPAN_W'(sx);
      c.span_y  = SPAN_W'(sy);
      c.shape   = BYTE_W'(shape);
      c.edge_ch = BYTE_W'(ch);
      return c;
   endfunction

   function automatic dir_row_type mk_row(input raster_cmd_type c, input bit typed,
                                          input int want_ch, input bit st);
      dir_row_type d;
      d.cmd = c;
      d.ans = '{typed: typed, rsp: '{cell_ch: CHAR_W'(want_ch), status: st}};
      return d;
   endfunction

   // random command sized to the area in use; mostly well-formed draws
   function automatic raster_cmd_type rand_cmd(input bit pick_any,
                                               input logic [KIND_W-1:0] kind);
      raster_cmd_type c;
      int unsigned    cols, rows, roll;
      cols = dim_used(mirror_width);
      rows = dim_used(mirror_height);
      c    = plain_cmd(kind);
      if (pick_any) begin
         roll = $urandom_range(0, 99);
         c.kind = (roll < 10) ? KIND_CLEAR : (roll < 55) ? KIND_DRAW :
                  (roll < 95) ? KIND_READ : KIND_UNUSED;
      end
      if (c.kind == KIND_DRAW) begin
         if ($urandom_range(0, 99) < 80) begin
            c.shape   = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
            c.edge_ch = BYTE_W'($urandom_range(CHAR_MIN, CHAR_MAX));
            c.left    = POS_W'(int'($urandom_range(0, (cols + 4) * UNIT)) - 2 * UNIT);
            c.top     = POS_W'(int'($urandom_range(0, (rows + 4) * UNIT)) - 2 * UNIT);
            c.span_x  = ($urandom_range(0, 3) == 0) ?
                        SPAN_W'($urandom_range(1, 2 * UNIT - 1)) :
                        SPAN_W'($urandom_range(1, (cols + 2) * UNIT));
            c.span_y  = ($urandom_range(0, 3) == 0) ?
                        SPAN_W'($urandom_range(1, 2 * UNIT - 1)) :
                        SPAN_W'($urandom_range(1, (rows + 2) * UNIT));
         end else if ($urandom_range(0, 1)) begin
            // raw fields, but with a legal shape so the other checks matter
            c.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
         end
      end else if (c.kind == KIND_READ) begin
         if ($urandom_range(0, 99) < 80 && cols > 0 && rows > 0) begin
            c.col = BYTE_W'($urandom_range(0, cols - 1));
            c.row = BYTE_W'($urandom_range(0, rows - 1));
         end
         if (c.col < cols && c.row < rows && !cleared[c.row*MAX_DIM + c.col])
            c.kind = KIND_CLEAR;
      end
      return c;
   endfunction

   // drives one request beat and returns at the edge it is taken
   task automatic issue_cmd(input raster_cmd_type c, input typed_rsp_type ans);
      int unsigned gap, cols, rows;
      int          r, k;
      if (c.kind == KIND_CLEAR) begin
         cols = dim_used(mirror_width);
         rows = dim_used(mirror_height);
         for (r = 0; r < rows; r++)
            for (k = 0; k < cols; k++)
               cleared[r*MAX_DIM + k] = 1'b1;
      end
      typed_rsp_q.push_back(ans);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind        <= c.kind;
      req_rect_left   <= c.left;
      req_rect_top    <= c.top;
      req_rect_span_x <= c.span_x;
      req_rect_span_y <= c.span_y;
      req_shape_code  <= c.shape;
      req_edge_char   <= c.edge_ch;
      req_read_col    <= c.col;
      req_read_row    <= c.row;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and wait until every response beat is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cell_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // register writes on back-to-back edges; block must be idle
   task automatic write_regs(input logic [CSR_DAT_W-1:0] w, input logic [CSR_DAT_W-1:0] h,
                             input logic [CSR_DAT_W-1:0] bg, input bit poke_unused);
      csr_wen   <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_BG;
      csr_wdata <= bg;
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= CSR_DAT_W'($urandom);
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      mirror_width  = w;
      mirror_height = h;
      mirror_bg     = bg[CHAR_W-1:0];
   endtask

   task automatic run_phase(input logic [CSR_DAT_W-1:0] w, input logic [CSR_DAT_W-1:0] h,
                            input logic [CSR_DAT_W-1:0] bg, input int n, input bit drain_mid);
      int i;
      wait_idle();
      write_regs(w, h, bg, 1'b0);
      issue_cmd(plain_cmd(KIND_CLEAR), NO_ANSWER);
      for (i = 0; i < n; i++) begin
         if (drain_mid && i == n / 2)
            wait_idle();
         issue_cmd(rand_cmd(1'b1, KIND_CLEAR), NO_ANSWER);
      end
   endtask

   initial begin : stimulus
      int i;
      // reset defaults: one cell in use, space background
      dir_rows.push_back(mk_row(plain_cmd(KIND_CLEAR), 1, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(0, 0), 1, BG_RESET, 0));
      dir_rows.push_back(mk_row(read_cmd(1, 0), 1, 0, 0));
      // 10 x 6 area, '#' background
      dir_rows.push_back(mk_row(plain_cmd(KIND_CLEAR), 1, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(0, 0), 1, BG_DIRECTED, 0));
      dir_rows.push_back(mk_row(read_cmd(9, 5), 1, BG_DIRECTED, 0));
      dir_rows.push_back(mk_row(read_cmd(10, 0), 1, 0, 0));
      // rejected draws
      dir_rows.push_back(mk_row(draw_cmd(0, 0, UNIT, UNIT, 8'h00, 8'd42), 1, 0, 1));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, UNIT, UNIT, 8'hFF, 8'd42), 1, 0, 1));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, 0, UNIT, SHAPE_FILLED, 8'd42), 1, 0, 1));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, UNIT, 0, SHAPE_OUTLINE, 8'd42), 1, 0, 1));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, UNIT, UNIT, SHAPE_FILLED, 8'd31), 1, 0, 1));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, UNIT, UNIT, SHAPE_FILLED, 8'd127), 1, 0, 1));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, UNIT, UNIT, SHAPE_OUTLINE, 8'd255), 1, 0, 1));
      // unused kind
      dir_rows.push_back(mk_row(plain_cmd(KIND_UNUSED), 1, 0, 0));
      // small filled box, then read its interior
      dir_rows.push_back(mk_row(draw_cmd(UNIT, UNIT, 3 * UNIT, 2 * UNIT, SHAPE_FILLED, 8'd42),
                                1, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(2, 2), 0, 0, 0));
      // coordinate extremes, both outside the area
      dir_rows.push_back(mk_row(draw_cmd(POS_MIN, POS_MIN, SPAN_MAX, SPAN_MAX, SHAPE_OUTLINE,
                                         CHAR_MAX), 1, 0, 0));
      dir_rows.push_back(mk_row(draw_cmd(POS_MAX, POS_MAX, SPAN_MAX, SPAN_MAX, SHAPE_FILLED,
                                         CHAR_MIN), 1, 0, 0));
      // outline on fractional corners
      dir_rows.push_back(mk_row(draw_cmd(UNIT / 2, -UNIT / 4, 7 * UNIT + UNIT / 4, 4 * UNIT,
                                         SHAPE_OUTLINE, 8'd111), 0, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(4, 3), 0, 0, 0));
      // filled over the whole area, then outline on exact cell edges
      dir_rows.push_back(mk_row(draw_cmd(-UNIT, -UNIT, SPAN_MAX, SPAN_MAX, SHAPE_FILLED,
                                         8'd65), 0, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(5, 3), 0, 0, 0));
      dir_rows.push_back(mk_row(draw_cmd(0, 0, 9 * UNIT, 5 * UNIT, SHAPE_OUTLINE, 8'd43),
                                0, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(9, 0), 0, 0, 0));
      dir_rows.push_back(mk_row(read_cmd(4, 2), 0, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < dir_rows.size(); i++) begin
         if (i == RESET_ROWS) begin
            wait_idle();
            write_regs(9'd10, 9'd6, CSR_DAT_W'(BG_DIRECTED), 1'b1);
         end
         issue_cmd(dir_rows[i].cmd, dir_rows[i].ans);
      end

      // random phases over several area sizes
      run_phase(9'd16, 9'd12, CSR_DAT_W'($urandom), 16, 1'b1);
      run_phase(9'd1, 9'd1, CSR_DAT_W'(CHAR_MAX), 8, 1'b0);
      run_phase(9'd0, 9'd300, CSR_DAT_W'(CHAR_MIN), 6, 1'b0);

      // full size with saturated width: few sweeps, many reads
      wait_idle();
      write_regs(9'h1FF, CSR_DAT_W'(MAX_DIM), 9'h07F, 1'b0);
      issue_cmd(plain_cmd(KIND_CLEAR), NO_ANSWER);
      for (i = 0; i < 10; i++)
         issue_cmd(rand_cmd(1'b0, (i == 0 || i == 5) ? KIND_DRAW : KIND_READ), NO_ANSWER);

      // long sink hold-off while requests keep coming, queue must back up
      no_idle = 1'b1;
      wait_idle();
      write_regs(9'd4, 9'd4, CSR_DAT_W'($urandom_range(CHAR_MIN, CHAR_MAX)), 1'b0);
      sink_hold_req = 1'b1;
      issue_cmd(plain_cmd(KIND_CLEAR), NO_ANSWER);
      for (i = 0; i < 13; i++)
         issue_cmd(rand_cmd(1'b1, KIND_CLEAR), NO_ANSWER);
      run_phase(CSR_DAT_W'($urandom_range(1, 32)), CSR_DAT_W'($urandom_range(1, 32)),
                CSR_DAT_W'($urandom), 12, 1'b0);
      no_idle = 1'b0;
      run_phase(CSR_DAT_W'($urandom_range(1, 32)), CSR_DAT_W'($urandom_range(1, 32)),
                9'h000, 12, 1'b0);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_cell_rsp.size() != 0) begin
         $display("%0t: %0d response beats never arrived", $time, pending_cell_rsp.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
